@@ hdl/assert_macros.svh @@
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/plist_pkg.sv @@
package plist_pkg;

    localparam int PLIST_CAPACITY = 32;
    localparam int DATA_W         = 32;
    localparam int POS_W          = 6;
    localparam int MODE_W         = 3;
    localparam int STATUS_W       = 2;
    localparam int LEN_W          = 6;
    localparam int IN_W           = 48;
    localparam int OUT_W          = 48;

    localparam logic [MODE_W-1:0] MODE_RETRIEVE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REPLACE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd3;

    // Broadcast from the control logic to every cell of the row.
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic              wr;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } ctl_t;

endpackage

@@ hdl/plist_cell.sv @@
module plist_cell #(
    parameter int IDX = 0
) (
    input  logic                          clk,
    input  plist_pkg::ctl_t               ctl,
    input  logic [plist_pkg::DATA_W-1:0]  left,   // word of the cell below
    input  logic [plist_pkg::DATA_W-1:0]  right,  // word of the cell above
    output logic [plist_pkg::DATA_W-1:0]  word,
    output logic [plist_pkg::DATA_W-1:0]  rd
);
    import plist_pkg::*;

    localparam logic [POS_W-1:0] IDX_P = POS_W'(IDX);

    logic [DATA_W-1:0] word_reg;
    logic [DATA_W-1:0] word_next;
    logic              sel;

    assign sel  = (ctl.pos == IDX_P);
    assign word = word_reg;
    assign rd   = sel ? word_reg : '0;

    always_comb
    begin
        word_next = word_reg;
        if (ctl.ins)
        begin
            // shift up above the insertion point, take the new word at it
            if (ctl.pos < IDX_P)
                word_next = left;
            else if (sel)
                word_next = ctl.value;
        end
        else if (ctl.rem)
        begin
            if (ctl.pos <= IDX_P)
                word_next = right;
        end
        else if (ctl.wr && sel)
        begin
            word_next = ctl.value;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

@@ hdl/positional_list_engine_top.sv @@
// An accepted request's result is registered and reaches the m_ side in the next cycle.
// Throughput: one request per cycle; every cell of the row shifts in the same
//   cycle, and the output register frees s_tready whenever its result is taken.
// Reset: rst_n (asynchronous, active low) empties the list and the output
//   register; stored words keep their bits and are only read after a write.
module positional_list_engine_top #(
    parameter int CAPACITY = plist_pkg::PLIST_CAPACITY
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [2:0] mode, [8:3] position, [40:9] value_in, [47:41] zero
    input  logic [plist_pkg::IN_W-1:0]   s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [1:0] status, [33:2] value_out, [39:34] length, [40] is_full,
    // [41] is_empty, [47:42] zero
    output logic [plist_pkg::OUT_W-1:0]  m_tdata
);
    import plist_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int RES_W = STATUS_W + DATA_W + LEN_W + 2;

    logic [CNT_W-1:0]    used_reg;
    logic [CNT_W-1:0]    used_next;
    logic                out_valid_reg;
    logic [RES_W-1:0]    out_data_reg;
    logic [RES_W-1:0]    out_data_next;

    logic                acc;
    logic [MODE_W-1:0]   mode;
    logic [POS_W-1:0]    pos;
    logic [DATA_W-1:0]   value_in;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    used_ext;
    logic [STATUS_W-1:0] status;
    logic                ins_ok;
    logic                rem_ok;
    logic                wr_ok;
    logic                rd_ok;
    logic [DATA_W-1:0]   rd_bus;
    logic [DATA_W-1:0]   value_out;
    logic                is_full;
    logic                is_empty;
    ctl_t                ctl;

    logic [DATA_W-1:0]   cell_word [CAPACITY];
    logic [DATA_W-1:0]   cell_rd   [CAPACITY];

    assign acc      = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;
    assign mode     = s_tdata[MODE_W-1:0];
    assign pos      = s_tdata[MODE_W+POS_W-1:MODE_W];
    assign value_in = s_tdata[MODE_W+POS_W+DATA_W-1:MODE_W+POS_W];
    assign pos_ext  = CMP_W'(pos);
    assign used_ext = CMP_W'(used_reg);

    always_comb
    begin
        status    = ST_OK;
        ins_ok    = 1'b0;
        rem_ok    = 1'b0;
        wr_ok     = 1'b0;
        rd_ok     = 1'b0;
        used_next = used_reg;
        case (mode)
            MODE_RETRIEVE:
            begin
                if (pos_ext >= used_ext)
                    status = ST_RANGE;
                else
                    rd_ok = 1'b1;
            end
            MODE_REPLACE:
            begin
                if (pos_ext >= used_ext)
                    status = ST_RANGE;
                else
                    wr_ok = 1'b1;
            end
            MODE_INSERT:
            begin
                // full is checked before the position
                if (used_reg == CNT_W'(CAPACITY))
                    status = ST_OVER;
                else if (pos_ext > used_ext)
                    status = ST_RANGE;
                else
                begin
                    ins_ok    = 1'b1;
                    used_next = CNT_W'(used_reg + 1'b1);
                end
            end
            MODE_REMOVE:
            begin
                if (used_reg == '0)
                    status = ST_UNDER;
                else if (pos_ext >= used_ext)
                    status = ST_RANGE;
                else
                begin
                    rem_ok    = 1'b1;
                    rd_ok     = 1'b1;
                    used_next = CNT_W'(used_reg - 1'b1);
                end
            end
            MODE_CLEAR:
            begin
                used_next = '0;
            end
            default:
            begin
                status = ST_RANGE;
            end
        endcase
    end

    assign ctl.ins   = acc && ins_ok;
    assign ctl.rem   = acc && rem_ok;
    assign ctl.wr    = acc && wr_ok;
    assign ctl.pos   = pos;
    assign ctl.value = value_in;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DATA_W-1:0] left_w;
            logic [DATA_W-1:0] right_w;
            if (gi == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = cell_word[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = cell_word[gi+1];
            end
            plist_cell #(
                .IDX (gi)
            ) u_cell (
                .clk   (clk),
                .ctl   (ctl),
                .left  (left_w),
                .right (right_w),
                .word  (cell_word[gi]),
                .rd    (cell_rd[gi])
            );
        end
    endgenerate

    // at most one cell drives a nonzero read word
    always_comb
    begin
        rd_bus = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_bus = rd_bus | cell_rd[i];
    end

    assign value_out     = rd_ok ? rd_bus : '0;
    assign is_full       = (used_next == CNT_W'(CAPACITY));
    assign is_empty      = (used_next == '0);
    assign out_data_next = {is_empty, is_full, LEN_W'(used_next), value_out, status};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                used_reg      <= used_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_bound, used_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `ASSERT_NEXT(a_insert_grows, acc && ins_ok, used_reg == CNT_W'($past(used_reg) + 1'b1), "insert did not grow the list")
    `ASSERT_ALWAYS(a_over_full, !(out_valid_reg && out_data_reg[STATUS_W-1:0] == ST_OVER) || out_data_reg[RES_W-2], "overflow reported on a list that is not full")
    `ASSERT_ALWAYS(a_full_empty, !(out_valid_reg && out_data_reg[RES_W-1] && out_data_reg[RES_W-2]), "full and empty flags both set")

endmodule
